/* src/rpfa_pkg.sv */
`timescale 1ns / 1ps
// Shared types, action and status codes, and default sizes for the
// page frame allocator. No dependencies.
package rpfa_pkg;

  localparam int NUM_PAGES_DEF  = 65536;
  localparam int COUNT_BITS_DEF = 8;

  localparam logic [2:0] ACT_ALLOC = 3'd0;
  localparam logic [2:0] ACT_FREE  = 3'd1;
  localparam logic [2:0] ACT_ADD   = 3'd2;
  localparam logic [2:0] ACT_INC   = 3'd3;
  localparam logic [2:0] ACT_DEC   = 3'd4;
  localparam logic [2:0] ACT_READ  = 3'd5;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_NOFRAME = 2'd1;
  localparam logic [1:0] STS_OUTSIDE = 2'd2;
  localparam logic [1:0] STS_FULL    = 2'd3;

  localparam logic REG_POOL_LOW  = 1'b0;
  localparam logic REG_POOL_HIGH = 1'b1;

  localparam logic [16:0] POOL_HIGH_RST = 17'h10000;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] page;
  } rpfa_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] granted_page;
    logic [7:0]  ref_count;
    logic [16:0] free_count;
  } rpfa_out_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic exec;
  } rpfa_cmd_t;

  typedef struct packed {
    logic clr_last;
  } rpfa_stat_t;

endpackage

/* src/refcounted_page_frame_allocator_unit.sv */
`timescale 1ns / 1ps
// Top level of the reference-counted page frame allocator.
// Depends on rpfa_pkg, rpfa_regs, rpfa_ctrl, rpfa_dp, rpfa_ram.
//
// After reset the block holds busy high while it clears the reference
// count table, one entry per cycle; configuration writes are taken during
// that time. Each transaction then runs thus: start is taken at an edge
// where busy is low, the next cycle reads the count and the top of the
// free stack out of their RAMs and writes the update, and the result
// appears with out_strobe for exactly one cycle right after, during which
// busy is already low again. Because of the read-modify-write of the count
// RAM, a new start is not taken while a transaction executes. The
// receiver cannot stall: a result must be taken in its strobe cycle.
module refcounted_page_frame_allocator_unit #(
  parameter int NUM_PAGES  = rpfa_pkg::NUM_PAGES_DEF,
  parameter int COUNT_BITS = rpfa_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rpfa_pkg::rpfa_in_t  in_item,
  output logic                out_strobe,
  output rpfa_pkg::rpfa_out_t out_result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import rpfa_pkg::*;

  rpfa_cmd_t   cmd;
  rpfa_stat_t  stat;
  logic [15:0] pool_low;
  logic [16:0] pool_high;

  rpfa_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .pool_low  (pool_low),
    .pool_high (pool_high)
  );

  rpfa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  rpfa_dp #(
    .NUM_PAGES  (NUM_PAGES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_item    (in_item),
    .pool_low   (pool_low),
    .pool_high  (pool_high),
    .out_strobe (out_strobe),
    .out_result (out_result)
  );

endmodule

/* src/rpfa_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rpfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/rpfa_regs.sv */
`timescale 1ns / 1ps
// APB-style configuration registers: pool low page and pool high page.
// Depends on rpfa_pkg.
module rpfa_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] pool_low,
  output logic [16:0] pool_high
);
  import rpfa_pkg::*;

  logic [15:0] pool_low_r;
  logic [15:0] pool_low_nxt;
  logic [16:0] pool_high_r;
  logic [16:0] pool_high_nxt;
  logic        wr_en;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_comb begin
    pool_low_nxt  = pool_low_r;
    pool_high_nxt = pool_high_r;
    if (wr_en) begin
      if (reg_sel == REG_POOL_LOW) begin
        pool_low_nxt = pwdata[15:0];
      end else begin
        pool_high_nxt = pwdata[16:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_low_r  <= '0;
      pool_high_r <= POOL_HIGH_RST;
    end else begin
      pool_low_r  <= pool_low_nxt;
      pool_high_r <= pool_high_nxt;
    end
  end

  always_comb begin
    if (reg_sel == REG_POOL_LOW) begin
      prdata = {16'd0, pool_low_r};
    end else begin
      prdata = {15'd0, pool_high_r};
    end
  end

  assign pool_low  = pool_low_r;
  assign pool_high = pool_high_r;

endmodule

/* src/rpfa_ctrl.sv */
`timescale 1ns / 1ps
// Controller: clears the count table after reset, then sequences each
// transaction through accept and execute. Depends on rpfa_pkg.
module rpfa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  rpfa_pkg::rpfa_stat_t stat,
  output rpfa_pkg::rpfa_cmd_t  cmd,
  output logic                 busy
);
  import rpfa_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign cmd.clear  = (state_r == ST_CLEAR);
  assign cmd.accept = (state_r == ST_IDLE) && start;
  assign cmd.exec   = (state_r == ST_EXEC);

endmodule

/* src/rpfa_dp.sv */
`timescale 1ns / 1ps
// Datapath: count table and free stack memories, stack depth, action
// evaluation and result register. Depends on rpfa_pkg and rpfa_ram.
module rpfa_dp #(
  parameter int NUM_PAGES  = rpfa_pkg::NUM_PAGES_DEF,
  parameter int COUNT_BITS = rpfa_pkg::COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rpfa_pkg::rpfa_cmd_t  cmd,
  output rpfa_pkg::rpfa_stat_t stat,
  input  rpfa_pkg::rpfa_in_t   in_item,
  input  logic [15:0]          pool_low,
  input  logic [16:0]          pool_high,
  output logic                 out_strobe,
  output rpfa_pkg::rpfa_out_t  out_result
);
  import rpfa_pkg::*;

  localparam int AW = $clog2(NUM_PAGES);
  localparam int DW = $clog2(NUM_PAGES + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [2:0]            act_r;
  logic [15:0]           page_r;
  logic [AW-1:0]         clr_addr_r;
  logic [DW-1:0]         depth_r;
  logic [DW-1:0]         depth_nxt;
  logic                  out_strobe_r;
  rpfa_out_t             out_r;
  rpfa_out_t             out_nxt;

  logic                  cnt_we;
  logic [AW-1:0]         cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [COUNT_BITS-1:0] cnt_rdata;
  logic                  stk_push;
  logic                  stk_pop;
  logic [15:0]           stk_rdata;

  logic                  ex_we;
  logic [AW-1:0]         ex_waddr;
  logic [COUNT_BITS-1:0] ex_wdata;
  logic                  in_pool;
  logic                  stk_full;

  assign stat.clr_last = (clr_addr_r == AW'(NUM_PAGES - 1));

  assign in_pool  = (page_r >= pool_low) && (17'(page_r) < pool_high)
                    && (32'(page_r) < 32'(NUM_PAGES));
  assign stk_full = (depth_r == DW'(NUM_PAGES));

  always_comb begin
    logic [COUNT_BITS-1:0] c_new;
    c_new    = cnt_rdata;
    ex_we    = 1'b0;
    ex_waddr = AW'(page_r);
    ex_wdata = '0;
    stk_push = 1'b0;
    stk_pop  = 1'b0;
    out_nxt.status       = STS_OK;
    out_nxt.granted_page = '0;
    out_nxt.ref_count    = '0;
    if (act_r == ACT_ALLOC) begin
      if (depth_r == '0) begin
        out_nxt.status = STS_NOFRAME;
      end else begin
        stk_pop              = 1'b1;
        out_nxt.granted_page = stk_rdata;
        if (32'(stk_rdata) < 32'(NUM_PAGES)) begin
          ex_we             = 1'b1;
          ex_waddr          = AW'(stk_rdata);
          ex_wdata          = COUNT_BITS'(1);
          out_nxt.ref_count = 8'd1;
        end
      end
    end else if (act_r <= ACT_READ) begin
      if (!in_pool) begin
        out_nxt.status = STS_OUTSIDE;
      end else begin
        case (act_r)
          ACT_FREE, ACT_ADD: begin
            if (act_r == ACT_ADD) begin
              c_new = '0;
            end else if (cnt_rdata != '0) begin
              c_new = cnt_rdata - COUNT_BITS'(1);
            end
            ex_we = 1'b1;
            if (c_new == '0) begin
              if (stk_full) begin
                out_nxt.status = STS_FULL;
              end else begin
                stk_push = 1'b1;
              end
            end
          end
          ACT_INC: begin
            if (cnt_rdata != CNT_MAX) begin
              c_new = cnt_rdata + COUNT_BITS'(1);
            end
            ex_we = 1'b1;
          end
          ACT_DEC: begin
            if (cnt_rdata != '0) begin
              c_new = cnt_rdata - COUNT_BITS'(1);
            end
            ex_we = 1'b1;
          end
          default: begin
            c_new = cnt_rdata;
          end
        endcase
        ex_wdata          = c_new;
        out_nxt.ref_count = 8'(c_new);
      end
    end
    stk_push = stk_push && cmd.exec;
    stk_pop  = stk_pop && cmd.exec;
    ex_we    = ex_we && cmd.exec;
    if (stk_pop) begin
      depth_nxt = depth_r - DW'(1);
    end else if (stk_push) begin
      depth_nxt = depth_r + DW'(1);
    end else begin
      depth_nxt = depth_r;
    end
    out_nxt.free_count = 17'(depth_nxt);
  end

  assign cnt_we    = cmd.clear || ex_we;
  assign cnt_waddr = cmd.clear ? clr_addr_r : ex_waddr;
  assign cnt_wdata = cmd.clear ? '0 : ex_wdata;

  rpfa_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_PAGES)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cmd.accept),
    .raddr (AW'(in_item.page)),
    .rdata (cnt_rdata)
  );

  rpfa_ram #(
    .WIDTH (16),
    .DEPTH (NUM_PAGES)
  ) u_stk_ram (
    .clk   (clk),
    .we    (stk_push),
    .waddr (AW'(depth_r)),
    .wdata (page_r),
    .re    (cmd.accept),
    .raddr (AW'(depth_r - DW'(1))),
    .rdata (stk_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r   <= '0;
      depth_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      depth_r      <= depth_nxt;
      out_strobe_r <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r  <= in_item.action;
      page_r <= in_item.page;
    end
    if (cmd.exec) begin
      out_r <= out_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_result = out_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(depth_r) <= 32'(NUM_PAGES))
    else $error("stack depth beyond frame count");

  a_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(stk_push && stk_pop))
    else $error("push and pop in the same cycle");

  a_strobe_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(cmd.exec))
    else $error("result strobe without an executed transaction");

  a_free_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> (out_r.free_count == 17'(depth_r)))
    else $error("reported free count differs from stack depth");

endmodule

/* bench/tb_refcounted_page_frame_allocator_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the page frame allocator: drives frame actions and
// pool register writes and compares every result with an in-bench prediction.
// Depends on rpfa_pkg and refcounted_page_frame_allocator_unit.
module tb_refcounted_page_frame_allocator_unit;
  import rpfa_pkg::*;

  localparam int          WATCHDOG_LIMIT = 200000;
  localparam logic [16:0] STACK_FULL     = 17'h10000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  rpfa_in_t    in_item;
  logic        out_strobe;
  rpfa_out_t   out_result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [7:0]  frame_refs [0:65535];
  logic [15:0] free_frames [0:65535];
  logic [16:0] free_depth;
  logic [15:0] pool_low_cfg;
  logic [16:0] pool_high_cfg;
  logic [15:0] last_granted;

  rpfa_out_t   expected_results [$];
  rpfa_out_t   head_result;
  int          error_count;
  int          stall_cycles;

  refcounted_page_frame_allocator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_result(out_result),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic rpfa_out_t apply_frame_op(rpfa_in_t op);
    rpfa_out_t  r;
    logic [7:0] cnt;
    r   = '0;
    cnt = '0;
    if (op.action == ACT_ALLOC) begin
      if (free_depth == 0) begin
        r.status = STS_NOFRAME;
      end else begin
        free_depth = free_depth - 17'd1;
        r.granted_page = free_frames[free_depth[15:0]];
        frame_refs[r.granted_page] = 8'd1;
        r.ref_count = 8'd1;
      end
    end else if (op.action <= ACT_READ) begin
      if (op.page < pool_low_cfg || {1'b0, op.page} >= pool_high_cfg) begin
        r.status = STS_OUTSIDE;
      end else begin
        cnt = frame_refs[op.page];
        case (op.action)
          ACT_FREE, ACT_ADD: begin
            if (op.action == ACT_ADD) cnt = 8'd0;
            else if (cnt != 8'd0) cnt = cnt - 8'd1;
            frame_refs[op.page] = cnt;
            if (cnt == 8'd0) begin
              if (free_depth >= STACK_FULL) begin
                r.status = STS_FULL;
              end else begin
                free_frames[free_depth[15:0]] = op.page;
                free_depth = free_depth + 17'd1;
              end
            end
          end
          ACT_INC: begin
            if (cnt != 8'hFF) cnt = cnt + 8'd1;
            frame_refs[op.page] = cnt;
          end
          ACT_DEC: begin
            if (cnt != 8'd0) cnt = cnt - 8'd1;
            frame_refs[op.page] = cnt;
          end
          default: ;
        endcase
        r.ref_count = cnt;
      end
    end
    r.free_count = free_depth;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_result);
        error_count++;
      end else begin
        head_result = expected_results.pop_front();
        check_field("status", 32'(head_result.status), 32'(out_result.status));
        check_field("granted_page", 32'(head_result.granted_page),
                    32'(out_result.granted_page));
        check_field("ref_count", 32'(head_result.ref_count), 32'(out_result.ref_count));
        check_field("free_count", 32'(head_result.free_count), 32'(out_result.free_count));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (psel && penable && pwrite)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Leave start high on return so back-to-back transactions need no toggle.
  task automatic issue_frame_op(input logic [2:0] act, input logic [15:0] pg);
    rpfa_in_t  op;
    rpfa_out_t predicted;
    op.action = act;
    op.page   = pg;
    start   <= 1'b1;
    in_item <= op;
    do @(posedge clk); while (busy);
    predicted = apply_frame_op(op);
    if (act == ACT_ALLOC && predicted.status == STS_OK) last_granted = predicted.granted_page;
    expected_results.push_back(predicted);
  endtask

  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_pool_reg(input logic reg_sel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (reg_sel == REG_POOL_LOW) pool_low_cfg = value[15:0];
    else pool_high_cfg = value[16:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_pool(input int lo, input int hi);
    drain_results();
    write_pool_reg(REG_POOL_LOW, 32'(lo));
    write_pool_reg(REG_POOL_HIGH, 32'(hi));
  endtask

  task automatic test_directed_cases();
    set_pool(0, 65536);
    issue_frame_op(ACT_ALLOC, 16'hFFFF);
    issue_frame_op(ACT_READ, 16'h0000);
    issue_frame_op(ACT_READ, 16'hFFFF);
    issue_frame_op(ACT_DEC, 16'h0005);
    issue_frame_op(ACT_FREE, 16'h0007);
    issue_frame_op(ACT_ADD, 16'hFFFF);
    issue_frame_op(ACT_ADD, 16'h0000);
    issue_frame_op(ACT_ALLOC, 16'h1234);
    issue_frame_op(ACT_INC, 16'h0000);
    issue_frame_op(ACT_FREE, 16'h0000);
    issue_frame_op(ACT_FREE, 16'h0000);
    issue_frame_op(3'd6, 16'hFFFF);
    issue_frame_op(3'd7, 16'hAAAA);
    repeat (4) issue_frame_op(ACT_ALLOC, 16'h5555);
    set_pool(65535, 65536);
    issue_frame_op(ACT_READ, 16'hFFFE);
    issue_frame_op(ACT_INC, 16'hFFFF);
    issue_frame_op(ACT_FREE, 16'h0000);
    set_pool(0, 1);
    issue_frame_op(ACT_READ, 16'h0001);
    issue_frame_op(ACT_ADD, 16'h0000);
    issue_frame_op(ACT_INC, 16'hFFFF);
    set_pool(100, 50);
    issue_frame_op(ACT_READ, 16'd60);
    issue_frame_op(ACT_ALLOC, 16'd0);
    issue_frame_op(ACT_ALLOC, 16'd0);
  endtask

  task automatic test_count_saturation();
    set_pool(0, 65536);
    issue_frame_op(ACT_ADD, 16'h1234);
    repeat (260) issue_frame_op(ACT_INC, 16'h1234);
    issue_frame_op(ACT_READ, 16'h1234);
    repeat (260) issue_frame_op(ACT_DEC, 16'h1234);
    issue_frame_op(ACT_INC, 16'h1234);
    issue_frame_op(ACT_FREE, 16'h1234);
  endtask

  task automatic test_random_phase(input int lo, input int hi, input int count, input bit burst);
    int          done;
    int          pick;
    logic [2:0]  act;
    logic [15:0] pg;
    set_pool(lo, hi);
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) act = ACT_ALLOC;
      else if (pick < 40) act = ACT_FREE;
      else if (pick < 52) act = ACT_ADD;
      else if (pick < 67) act = ACT_INC;
      else if (pick < 77) act = ACT_DEC;
      else if (pick < 95) act = ACT_READ;
      else act = 3'($urandom_range(6, 7));
      pick = $urandom_range(0, 99);
      if (pick < 70 && hi > lo) pg = 16'($urandom_range(lo, hi - 1));
      else if (pick < 85) pg = last_granted;
      else pg = 16'($urandom());
      if (!burst) begin
        pick = $urandom_range(0, 99);
        if (pick < 2) drain_results();
        else if (pick >= 60 && pick < 95) hold_off($urandom_range(1, 4));
        else if (pick >= 95) hold_off($urandom_range(20, 120));
      end
      issue_frame_op(act, pg);
      if (act <= ACT_READ) done++;
    end
  endtask

  task automatic test_random_pools();
    int lo;
    lo = $urandom_range(0, 60000);
    test_random_phase(lo, lo + $urandom_range(16, 64), 180, 1'b0);
    test_random_phase(0, 32, 180, 1'b1);
    test_random_phase(65536 - 40, 65536, 180, 1'b0);
    test_random_phase($urandom_range(0, 65535), $urandom_range(1, 65536), 180, 1'b0);
  endtask

  task automatic test_stack_reuse();
    logic [15:0] pg;
    set_pool(0, 65536);
    pg = 16'($urandom());
    issue_frame_op(ACT_ADD, pg);
    issue_frame_op(ACT_FREE, pg);
    issue_frame_op(ACT_READ, pg);
    issue_frame_op(ACT_ALLOC, 16'h0000);
    issue_frame_op(ACT_INC, last_granted);
    issue_frame_op(ACT_ADD, 16'($urandom()));
    issue_frame_op(ACT_FREE, last_granted);
    issue_frame_op(ACT_FREE, last_granted);
    repeat (8) issue_frame_op(ACT_ALLOC, 16'($urandom()));
  endtask

  initial begin
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_item      <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    error_count  = 0;
    stall_cycles = 0;
    free_depth   = '0;
    last_granted = '0;
    pool_low_cfg  = '0;
    pool_high_cfg = POOL_HIGH_RST;
    for (int i = 0; i < 65536; i++) begin
      frame_refs[i]  = '0;
      free_frames[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_count_saturation();
    test_random_pools();
    test_stack_reuse();
    drain_results();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
